### hdl/fdiv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fdiv_pkg
// shared constants and the per-beat work record of the pipelined divider
// ----------------------------------------------------------------------------
package fdiv_pkg;

	localparam int FRAC_W         = 23;
	localparam int EXP_W          = 8;
	localparam int MANT_W         = FRAC_W + 1;
	localparam int QUO_W          = 26;
	localparam int REM_W          = MANT_W + 1;
	localparam int E_W            = 10;
	localparam int BITS_PER_STAGE = 2;
	localparam int NUM_STAGES     = QUO_W / BITS_PER_STAGE;

	localparam logic [MANT_W-1:0] HIDDEN_ONE = 24'h800000;
	localparam logic [E_W-1:0]    EXP_BIAS   = 10'd127;
	localparam logic [EXP_W-1:0]  EXP_MAX    = 8'hFF;

	// one item as it moves through the divide stages
	typedef struct packed {
		logic                    sign;
		logic                    special;
		logic [FRAC_W-1:0]       frac_a;
		logic signed [E_W-1:0]   expo;
		logic [MANT_W-1:0]       den;
		logic [REM_W-1:0]        rem;
		logic [QUO_W-1:0]        quo;
	} fdiv_work_t;

endpackage
`default_nettype wire

### hdl/fdiv_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fdiv_in_if
// operand channel: valid/ready with dividend and divisor
// ----------------------------------------------------------------------------
interface fdiv_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] dividend;
	logic [31:0] divisor;

	modport source (output valid, output dividend, output divisor, input ready);
	modport sink   (input valid, input dividend, input divisor, output ready);
endinterface
`default_nettype wire

### hdl/fdiv_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fdiv_out_if
// result channel: valid/ready with the quotient
// ----------------------------------------------------------------------------
interface fdiv_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] quotient;

	modport source (output valid, output quotient, input ready);
	modport sink   (input valid, input quotient, output ready);
endinterface
`default_nettype wire

### hdl/float32_divide.sv
`default_nettype none
// ----------------------------------------------------------------------------
// float32_divide
// pipelined single-precision divider
// ----------------------------------------------------------------------------
// Takes one operand beat per cycle while the result is not stalled and
// returns one quotient beat per beat, in order; each beat passes through
// one operand-unpack register, 13 restoring division stages that each
// retire two of the 26 quotient bits, and rounding and packing in front
// of the output register. The whole pipeline
// advances together whenever the output register is empty or being taken, so
// a stalled result holds every stage and nothing is dropped or duplicated.
// Rounding is to nearest even; no subnormals, infinities or NaNs are handled.
module float32_divide (
	input  wire logic   clk,
	input  wire logic   arst_n,
	fdiv_in_if.sink     operands,
	fdiv_out_if.source  result
);
	import fdiv_pkg::*;

	logic       en;
	logic       valid_v [0:NUM_STAGES];
	fdiv_work_t work_v  [0:NUM_STAGES];
	fdiv_work_t prep;
	logic [31:0] quotient_n;
	logic        out_valid_q;
	logic [31:0] quotient_q;

	assign en             = !out_valid_q || result.ready;
	assign operands.ready = en;

	// unpack operands
	always_comb begin
		prep         = '0;
		prep.sign    = operands.dividend[31] ^ operands.divisor[31];
		prep.special = (operands.divisor[30:23] == '0);
		prep.frac_a  = operands.dividend[22:0];
		prep.expo    = (operands.dividend[30:23] == '0) ? '0 :
		               ({2'b00, operands.dividend[30:23]} - {2'b00, operands.divisor[30:23]}
		                + EXP_BIAS);
		prep.den     = HIDDEN_ONE | {1'b0, operands.divisor[22:0]};
		prep.rem     = {1'b0, HIDDEN_ONE | {1'b0, operands.dividend[22:0]}};
		prep.quo     = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_v[0] <= 1'b0;
		end else if (en) begin
			valid_v[0] <= operands.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_v[0] <= prep;
		end
	end

	// division stages
	for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
		fdiv_stage u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_d (valid_v[i]),
			.work_d  (work_v[i]),
			.valid_q (valid_v[i+1]),
			.work_q  (work_v[i+1])
		);
	end

	fdiv_round u_round (
		.work     (work_v[NUM_STAGES]),
		.quotient (quotient_n)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_v[NUM_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quotient_q <= quotient_n;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.quotient = quotient_q;

	// a stalled result blocks new operands
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready) |-> !operands.ready)
		else $error("operands accepted while result stalled");

	// an accepted beat reaches the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(operands.valid && operands.ready) |=> valid_v[0])
		else $error("accepted beat lost at entry");

	// zero divisor exponent yields exponent field all ones
	a_special: assert property (@(posedge clk) disable iff (!arst_n)
		(en && valid_v[NUM_STAGES] && work_v[NUM_STAGES].special)
		|=> (result.valid && result.quotient[30:23] == EXP_MAX))
		else $error("zero divisor exponent not mapped to all ones");
endmodule
`default_nettype wire

### hdl/fdiv_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fdiv_stage
// one restoring-division stage: retires two quotient bits per beat
// ----------------------------------------------------------------------------
module fdiv_stage (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               valid_d,
	input  wire fdiv_pkg::fdiv_work_t work_d,
	output logic                    valid_q,
	output fdiv_pkg::fdiv_work_t    work_q
);
	import fdiv_pkg::*;

	fdiv_work_t work_n;

	// compare, subtract, shift for each bit of this stage
	always_comb begin
		logic [REM_W-1:0] r;
		logic [QUO_W-1:0] qv;
		logic             qbit;
		work_n = work_d;
		r      = work_d.rem;
		qv     = work_d.quo;
		for (int k = 0; k < BITS_PER_STAGE; k++) begin
			qbit = (r >= {1'b0, work_d.den});
			if (qbit) begin
				r = r - {1'b0, work_d.den};
			end
			r  = {r[REM_W-2:0], 1'b0};
			qv = {qv[QUO_W-2:0], qbit};
		end
		work_n.rem = r;
		work_n.quo = qv;
	end

	// valid travels with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_q <= work_n;
		end
	end
endmodule
`default_nettype wire

### hdl/fdiv_round.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fdiv_round
// normalize, round to nearest even, range check and pack the result
// ----------------------------------------------------------------------------
module fdiv_round (
	input  wire fdiv_pkg::fdiv_work_t work,
	output logic [31:0]          quotient
);
	import fdiv_pkg::*;

	logic [QUO_W:0]        q_r;
	logic signed [E_W-1:0] e_r;
	logic                  sticky;
	logic [FRAC_W-1:0]     frac;
	logic [EXP_W-1:0]      efield;

	assign sticky = |work.rem;

	// rounding point depends on whether the top quotient bit is set
	always_comb begin
		q_r = {1'b0, work.quo};
		e_r = work.expo;
		if (!work.quo[QUO_W-1]) begin
			if (q_r[0] && (sticky || q_r[1])) begin
				q_r = q_r + 27'd2;
			end
			if (!q_r[QUO_W-1]) begin
				q_r = q_r >> 1;
				e_r = e_r - 10'sd1;
			end else begin
				q_r = q_r >> 2;
			end
		end else begin
			if ((q_r[1:0] == 2'b11) || (q_r[1:0] == 2'b10 && (sticky || q_r[2]))) begin
				q_r = q_r + 27'd4;
			end
			q_r = q_r >> 2;
		end
	end

	assign frac   = q_r[FRAC_W-1:0];
	assign efield = (e_r[E_W-1] || (|e_r[E_W-2:EXP_W])) ? '0 : e_r[EXP_W-1:0];

	// divisor exponent zero bypasses the arithmetic
	assign quotient = work.special ? {work.sign, EXP_MAX, work.frac_a}
	                               : {work.sign, efield, frac};
endmodule
`default_nettype wire
